### design/mawp_pkg.sv
// Types and constants shared by the motion adaptive weave pixel block.
package mawp_pkg;

   localparam int unsigned PIXEL_W = 16;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPATIAL_TOLERANCE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMPORAL_TOLERANCE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIMILARITY_THRESHOLD = 8'd2;

   localparam logic [15:0] SPATIAL_TOLERANCE_RESET = 16'd600;
   localparam logic [15:0] TEMPORAL_TOLERANCE_RESET = 16'd1000;
   localparam logic signed [15:0] SIMILARITY_THRESHOLD_RESET = 16'sd25;

   typedef struct packed {
      logic [PIXEL_W-1:0] above_pixel;
      logic [PIXEL_W-1:0] current_pixel;
      logic [PIXEL_W-1:0] below_pixel;
      logic [PIXEL_W-1:0] previous_pixel;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] out_pixel;
      logic               used_weave;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        spatial_tolerance;
      logic [15:0]        temporal_tolerance;
      logic signed [15:0] similarity_threshold;
   } cfg_type;

endpackage

### design/mawp_if.sv
// Handshake interfaces for the request, response and register write channels.
interface mawp_req_if;
   logic              valid;
   logic              ready;
   mawp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mawp_rsp_if;
   logic              valid;
   logic              ready;
   mawp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mawp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mawp_pkg::CSR_INDEX_W-1:0]    index;
   logic [mawp_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### design/mawp_core.sv
// Weave or bob decision for one pixel word, purely combinational.
module mawp_core (
   input  mawp_pkg::cfg_type cfg_i,
   input  mawp_pkg::req_type req_i,
   output mawp_pkg::rsp_type rsp_o
);
   import mawp_pkg::*;

   function automatic logic [15:0] closeness(input logic [15:0] tol,
                                             input logic [7:0] n,
                                             input logic [7:0] c);
      logic signed [8:0]  diff;
      logic signed [7:0]  half;
      logic signed [15:0] sq;
      logic [15:0]        sq_u;
      diff = $signed({1'b0, n}) - $signed({1'b0, c});
      half = diff[8:1];
      sq = 16'(half) * 16'(half);
      sq_u = unsigned'(sq);
      closeness = (tol > sq_u) ? tol - sq_u : 16'd0;
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic logic [7:0] half_sum(input logic [7:0] a, input logic [7:0] b);
      half_sum = {1'b0, a[7:1]} + {1'b0, b[7:1]};
   endfunction

   logic [15:0] above_term;
   logic [15:0] below_term;
   logic [15:0] prev_term;
   logic [15:0] sum;
   logic        weave;
   logic [15:0] bob_pixel;

   always_comb begin
      above_term = closeness(cfg_i.spatial_tolerance, req_i.above_pixel[7:0],
                             req_i.current_pixel[7:0]);
      below_term = closeness(cfg_i.spatial_tolerance, req_i.below_pixel[7:0],
                             req_i.current_pixel[7:0]);
      prev_term = closeness(cfg_i.temporal_tolerance, req_i.previous_pixel[7:0],
                            req_i.current_pixel[7:0]);
      sum = sat_add(sat_add(above_term, below_term), prev_term);
      weave = $signed(sum) > cfg_i.similarity_threshold;
      bob_pixel = {half_sum(req_i.above_pixel[15:8], req_i.below_pixel[15:8]),
                   half_sum(req_i.above_pixel[7:0], req_i.below_pixel[7:0])};
      rsp_o.out_pixel = weave ? req_i.current_pixel : bob_pixel;
      rsp_o.used_weave = weave;
   end

endmodule

### design/motion_adaptive_weave_pixel.sv
// Top level of the motion adaptive weave pixel block.
// The block takes one request per clock unless the response channel stalls, and returns one
// response per request, the request being held in an input register and the decision in a
// result register. The sustained rate is one pixel word per cycle when not stalled, set by
// the combinational decision path (three small squares, a saturating sum and a signed compare).
// Register writes are taken in any cycle and should only happen while no request is in flight.
module motion_adaptive_weave_pixel (
   input logic clock,
   input logic reset,
   mawp_req_if.sink req_chan,
   mawp_rsp_if.source rsp_chan,
   mawp_csr_if.sink csr_chan
);
   import mawp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_data_ff;
   req_type s1_data_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   rsp_type core_rsp;
   logic    advance;
   logic    req_accept;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_SPATIAL_TOLERANCE: cfg_in.spatial_tolerance = csr_chan.data;
            CSR_TEMPORAL_TOLERANCE: cfg_in.temporal_tolerance = csr_chan.data;
            CSR_SIMILARITY_THRESHOLD: cfg_in.similarity_threshold = signed'(csr_chan.data);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   mawp_core u_core (
      .cfg_i(cfg_ff),
      .req_i(s1_data_ff),
      .rsp_o(core_rsp)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in = s1_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in = 1'b0;
         if (s1_valid_ff) begin
            rsp_data_in = core_rsp;
         end
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_data_in = req_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spatial_tolerance <= SPATIAL_TOLERANCE_RESET;
         cfg_ff.temporal_tolerance <= TEMPORAL_TOLERANCE_RESET;
         cfg_ff.similarity_threshold <= SIMILARITY_THRESHOLD_RESET;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_data_ff <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("Held request changed while the response stage was stalled.");

   a_backpressure_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("Request channel stalled while a stage was free.");

   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid_ff && s1_data_ff == $past(req_chan.data))
      else $error("Accepted request did not reach the input register.");

   a_spatial_write: assert property (@(posedge clock) disable iff (reset)
      csr_chan.valid && csr_chan.index == CSR_SPATIAL_TOLERANCE
      |=> cfg_ff.spatial_tolerance == $past(csr_chan.data))
      else $error("Spatial tolerance write was lost.");
`endif

endmodule
